// ===== hw/rtl/fdt_pkg.sv =====
// Shared types and constants for the fixed-point to decimal text converter.
package fdt_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned HalfW  = 16;
    localparam int unsigned DigW   = 4;
    localparam int unsigned IntDig = 5;
    localparam int unsigned FrcDig = 4;
    localparam int unsigned CntW   = 3;

    localparam logic [WordW-1:0] RoundAdd   = 32'd3;
    localparam logic [HalfW-1:0] RecipTen   = 16'hCCCD;
    localparam logic [CntW-1:0]  ConvLast   = 3'd4;
    localparam logic [CntW-1:0]  FrcLastIdx = 3'd3;

    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChDot   = 8'h2E;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;

    typedef enum logic [1:0] {
        SRC_SIGN,
        SRC_INT,
        SRC_DOT,
        SRC_FRAC
    } fdt_src_t;

    typedef struct packed {
        logic     load;
        logic     conv;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     push;
        fdt_src_t src;
        logic     last;
    } fdt_cmd_t;

    typedef struct packed {
        logic conv_done;
        logic neg;
        logic int_last;
        logic has_frac;
        logic frac_last;
        logic out_free;
    } fdt_sts_t;

endpackage

// ===== hw/rtl/fixed_to_decimal_text.sv =====
// Top level: 16.16 fixed-point word to ASCII decimal text, one number per request.
// Each request is loaded, run through the five-step digit extraction loop, and then
// emitted as N characters (N is 1 to 11), one character per cycle while out_ready allows;
// a new request is taken only after the last character has been pushed.
// Reset: asynchronous, active low; clears the controller state, the digit counter and output valid.
module fixed_to_decimal_text
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [fdt_pkg::WordW-1:0]   value,
    input  logic                        signed_mode,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic [7:0]                  text_char,
    output logic                        last_char,
    output logic                        out_valid,
    input  logic                        out_ready
);

    fdt_pkg::fdt_cmd_t cmd;
    fdt_pkg::fdt_sts_t sts;

    fdt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fdt_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .signed_mode (signed_mode),
        .cmd         (cmd),
        .sts         (sts),
        .text_char   (text_char),
        .last_char   (last_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (text_char == fdt_pkg::ChMinus) || (text_char == fdt_pkg::ChDot) ||
                      ((text_char >= fdt_pkg::ChZero) && (text_char <= fdt_pkg::ChNine)))
        else $error("output character outside the decimal text set");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new request taken during conversion");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid || out_ready))
        else $error("output register overwritten before it was taken");

endmodule

// ===== hw/rtl/fdt_datapath.sv =====
// Datapath: sign and rounding, digit extraction, digit store and output register.
module fdt_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [fdt_pkg::WordW-1:0]       value,
    input  logic                            signed_mode,
    input  fdt_pkg::fdt_cmd_t               cmd,
    output fdt_pkg::fdt_sts_t               sts,
    output logic [7:0]                      text_char,
    output logic                            last_char,
    output logic                            out_valid,
    input  logic                            out_ready
);

    logic                                   neg_reg;
    logic [fdt_pkg::HalfW-1:0]              hi_reg;
    logic [fdt_pkg::HalfW-1:0]              fr_reg;
    logic [fdt_pkg::CntW-1:0]               cnt_reg;
    logic [fdt_pkg::CntW-1:0]               nint_reg;
    logic [fdt_pkg::CntW-1:0]               flen_reg;
    logic [fdt_pkg::DigW-1:0]               int_dig_reg [fdt_pkg::IntDig];
    logic [fdt_pkg::DigW-1:0]               frc_dig_reg [fdt_pkg::FrcDig];
    logic                                   out_valid_reg;
    logic [7:0]                             text_char_reg;
    logic                                   last_char_reg;

    logic                                   neg_in;
    logic [fdt_pkg::WordW-1:0]              mag;
    logic [fdt_pkg::WordW-1:0]              mag_rnd;
    logic [2*fdt_pkg::HalfW-1:0]            recip_prod;
    logic [fdt_pkg::HalfW-1:0]              quot;
    logic [fdt_pkg::HalfW-1:0]              quot_x10;
    logic [fdt_pkg::DigW-1:0]               rem_dig;
    logic [fdt_pkg::HalfW+fdt_pkg::DigW-1:0] fr_x10;
    logic [fdt_pkg::CntW-1:0]               int_idx;
    logic [fdt_pkg::CntW-1:0]               cnt_p1;
    logic [fdt_pkg::DigW-1:0]               emit_dig;
    logic [7:0]                             emit_char;

    assign neg_in     = signed_mode & value[fdt_pkg::WordW-1];
    assign mag        = neg_in ? (~value + 32'd1) : value;
    assign mag_rnd    = mag + fdt_pkg::RoundAdd;

    assign recip_prod = hi_reg * fdt_pkg::RecipTen;
    assign quot       = {3'd0, recip_prod[31:19]};
    assign quot_x10   = (quot << 3) + (quot << 1);
    assign rem_dig    = fdt_pkg::DigW'(hi_reg - quot_x10);
    assign fr_x10     = ({4'd0, fr_reg} << 3) + ({4'd0, fr_reg} << 1);

    assign cnt_p1     = cnt_reg + 3'd1;
    assign int_idx    = nint_reg - 3'd1 - cnt_reg;

    always_comb
    begin
        emit_dig  = '0;
        emit_char = fdt_pkg::ChZero;
        case (cmd.src)
            fdt_pkg::SRC_SIGN: emit_char = fdt_pkg::ChMinus;
            fdt_pkg::SRC_DOT:  emit_char = fdt_pkg::ChDot;
            fdt_pkg::SRC_INT:
            begin
                emit_dig  = int_dig_reg[int_idx];
                emit_char = {4'h3, emit_dig};
            end
            fdt_pkg::SRC_FRAC:
            begin
                emit_dig  = frc_dig_reg[cnt_reg[1:0]];
                emit_char = {4'h3, emit_dig};
            end
            default: emit_char = fdt_pkg::ChZero;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg  <= neg_in;
            hi_reg   <= mag_rnd[31:16];
            fr_reg   <= mag_rnd[15:0];
            nint_reg <= 3'd1;
            flen_reg <= '0;
        end
        else if (cmd.conv)
        begin
            int_dig_reg[cnt_reg] <= rem_dig;
            hi_reg               <= quot;
            if (hi_reg != '0)
            begin
                nint_reg <= cnt_p1;
            end
            if (cnt_reg != fdt_pkg::ConvLast)
            begin
                frc_dig_reg[cnt_reg[1:0]] <= fr_x10[19:16];
                fr_reg                    <= fr_x10[15:0];
                if (fr_x10[19:16] != '0)
                begin
                    flen_reg <= cnt_p1;
                end
            end
        end
        if (cmd.push)
        begin
            text_char_reg <= emit_char;
            last_char_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load || cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.conv || cmd.cnt_inc)
            begin
                cnt_reg <= cnt_p1;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.conv_done = (cnt_reg == fdt_pkg::ConvLast);
    assign sts.neg       = neg_reg;
    assign sts.int_last  = (cnt_reg == nint_reg - 3'd1);
    assign sts.has_frac  = (flen_reg != '0);
    assign sts.frac_last = (cnt_reg == flen_reg - 3'd1) || (cnt_reg == fdt_pkg::FrcLastIdx);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign text_char = text_char_reg;
    assign last_char = last_char_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== hw/rtl/fdt_ctrl.sv =====
// Controller: sequences load, digit extraction and character emission.
module fdt_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fdt_pkg::fdt_sts_t   sts,
    output fdt_pkg::fdt_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_INT,
        ST_DOT,
        ST_FRAC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.src     = fdt_pkg::SRC_SIGN;
        in_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (sts.conv_done)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = sts.neg ? ST_SIGN : ST_INT;
                end
            end
            ST_SIGN:
            begin
                cmd.src = fdt_pkg::SRC_SIGN;
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_INT;
                end
            end
            ST_INT:
            begin
                cmd.src  = fdt_pkg::SRC_INT;
                cmd.last = sts.int_last && !sts.has_frac;
                if (sts.out_free)
                begin
                    cmd.push = 1'b1;
                    if (sts.int_last)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = sts.has_frac ? ST_DOT : ST_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            ST_DOT:
            begin
                cmd.src = fdt_pkg::SRC_DOT;
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                cmd.src  = fdt_pkg::SRC_FRAC;
                cmd.last = sts.frac_last;
                if (sts.out_free)
                begin
                    cmd.push = 1'b1;
                    if (sts.frac_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.cnt_inc = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
